// ===== sv/b64d_pkg.sv =====
// package for the base64 decoder: word types, status codes and symbol table
`default_nettype none

package b64d_pkg;

  localparam int unsigned SymW = 7;
  localparam int unsigned GrpN = 3;

  localparam logic [SymW-1:0] SYM_PAD = 7'd64;
  localparam logic [SymW-1:0] SYM_BAD = 7'd127;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_CHAR  = 3'd1,
    ST_BAD_PAD   = 3'd2,
    ST_EARLY_PAD = 3'd3,
    ST_TRUNC     = 3'd4
  } status_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       last_of_run;
  } out_word_t;

  // results raised by one input word, up to three
  typedef struct packed {
    logic [1:0]               count;
    out_word_t [GrpN-1:0]     words;
  } grp_t;

  function automatic logic [SymW-1:0] map_char(input logic [7:0] c);
    logic [SymW-1:0] s;
    s = SYM_BAD;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = SymW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = SymW'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = SymW'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s = 7'd62;
    end else if (c == 8'h2F) begin
      s = 7'd63;
    end else if (c == 8'h3D) begin
      s = SYM_PAD;
    end
    return s;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

`default_nettype wire

// ===== sv/base64_decoder_checked_core.sv =====
// top level of the streaming base64 decoder with error checking
//
// input channel: in_valid_i / in_stall_o / in_word_i, one word per character
// or an end-of-string mark. output channel: out_valid_o / out_stall_i /
// out_word_o, data bytes and one status word per string.
// an input word is taken into an input register, decoded combinationally into
// a result register, then handed out one output word per cycle while the
// receiver does not stall; each word passes both registers on its way out
// throughput: one input word per cycle while each word raises at most one
// output word and the receiver does not stall; a completed quad raises up to
// three, which the result register hands out one at a time, holding the input meanwhile
// skipped whitespace and the first three symbols of a quad raise nothing
// reset clears the quad position, the error code and both valid flags
// when the receiver stalls, the result register holds and in_stall_o rises
// once the input register is full
`default_nettype none

module base64_decoder_checked_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire b64d_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output b64d_pkg::out_word_t      out_word_o
);

  logic               in_valid_q, in_valid_d;
  b64d_pkg::in_word_t in_word_q;
  logic               accept;
  logic               step;
  logic               free;
  logic               load;
  b64d_pkg::grp_t     grp;

  always_comb begin
    step       = in_valid_q && free;
    in_stall_o = in_valid_q && !step;
    accept     = in_valid_i && !in_stall_o;
    load       = step && (grp.count != 2'd0);
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= in_word_i;
    end
  end

  b64d_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (in_word_q),
    .grp_o  (grp)
  );

  b64d_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .grp_i       (grp),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== sv/b64d_decode.sv =====
// quad state, error tracking and byte assembly for one word
`default_nettype none

module b64d_decode (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire b64d_pkg::in_word_t word_i,
  output b64d_pkg::grp_t          grp_o
);

  logic [1:0] quad_q, quad_d;
  logic [2:0] err_q, err_d;
  logic [b64d_pkg::SymW-1:0] store_q [b64d_pkg::GrpN];
  logic       wr_en;
  logic [b64d_pkg::SymW-1:0] sym;
  logic [b64d_pkg::SymW-1:0] v0, v1, v2;
  logic [7:0] b0, b1, b2;
  logic [2:0] st;

  always_comb begin
    sym = b64d_pkg::map_char(word_i.char_code);
    v0  = store_q[0];
    v1  = store_q[1];
    v2  = store_q[2];
    b0  = {v0[5:0], v1[5:4]};
    b1  = {v1[3:0], v2[5:2]};
    b2  = {v2[1:0], sym[5:0]};
    st  = err_q;
    if (err_q == 3'(b64d_pkg::ST_OK) && quad_q != 2'd0) begin
      st = 3'(b64d_pkg::ST_TRUNC);
    end
  end

  always_comb begin
    quad_d = quad_q;
    err_d  = err_q;
    wr_en  = 1'b0;
    grp_o  = '0;
    if (word_i.kind == b64d_pkg::KIND_END) begin
      grp_o.count    = 2'd1;
      grp_o.words[0] = '{is_status: 1'b1, data_byte: 8'd0, status: st, last_of_run: 1'b1};
      quad_d         = 2'd0;
      err_d          = 3'(b64d_pkg::ST_OK);
    end else if (err_q == 3'(b64d_pkg::ST_OK) && !b64d_pkg::is_blank(word_i.char_code)) begin
      if (sym == b64d_pkg::SYM_BAD) begin
        err_d = 3'(b64d_pkg::ST_BAD_CHAR);
      end else if (quad_q != 2'd3) begin
        wr_en  = 1'b1;
        quad_d = quad_q + 2'd1;
      end else begin
        quad_d = 2'd0;
        if (v2 == b64d_pkg::SYM_PAD && sym != b64d_pkg::SYM_PAD) begin
          err_d = 3'(b64d_pkg::ST_BAD_PAD);
        end else if (v0 == b64d_pkg::SYM_PAD || v1 == b64d_pkg::SYM_PAD) begin
          err_d = 3'(b64d_pkg::ST_EARLY_PAD);
        end else begin
          grp_o.words[0] = '{is_status: 1'b0, data_byte: b0,
                             status: 3'(b64d_pkg::ST_OK), last_of_run: 1'b0};
          grp_o.words[1] = '{is_status: 1'b0, data_byte: b1,
                             status: 3'(b64d_pkg::ST_OK), last_of_run: 1'b0};
          grp_o.words[2] = '{is_status: 1'b0, data_byte: b2,
                             status: 3'(b64d_pkg::ST_OK), last_of_run: 1'b1};
          if (v2 == b64d_pkg::SYM_PAD) begin
            grp_o.count                = 2'd1;
            grp_o.words[0].last_of_run = 1'b1;
          end else if (sym == b64d_pkg::SYM_PAD) begin
            grp_o.count                = 2'd2;
            grp_o.words[1].last_of_run = 1'b1;
          end else begin
            grp_o.count = 2'd3;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_q <= 2'd0;
      err_q  <= 3'(b64d_pkg::ST_OK);
    end else if (step_i) begin
      quad_q <= quad_d;
      err_q  <= err_d;
    end
  end

  // symbol store, written only at the first three places of a quad
  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) begin
      case (quad_q)
        2'd0:    store_q[0] <= sym;
        2'd1:    store_q[1] <= sym;
        2'd2:    store_q[2] <= sym;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/b64d_outq.sv =====
// result register that hands out a group of up to three words one at a time
`default_nettype none

module b64d_outq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire b64d_pkg::grp_t  grp_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output b64d_pkg::out_word_t  out_word_o
);

  logic                 valid_q, valid_d;
  logic [1:0]           cnt_q, cnt_d;
  logic [1:0]           idx_q, idx_d;
  b64d_pkg::out_word_t [b64d_pkg::GrpN-1:0] words_q;
  logic                 pop;
  logic                 last_pop;

  always_comb begin
    pop      = valid_q && !out_stall_i;
    last_pop = pop && (idx_q == cnt_q - 2'd1);
    free_o   = !valid_q || last_pop;
  end

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      cnt_d   = grp_i.count;
      idx_d   = 2'd0;
    end else if (last_pop) begin
      valid_d = 1'b0;
    end else if (pop) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    out_word_o = words_q[0];
      2'd1:    out_word_o = words_q[1];
      2'd2:    out_word_o = words_q[2];
      default: out_word_o = words_q[0];
    endcase
    out_valid_o = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 2'd0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      words_q <= grp_i.words;
    end
  end

endmodule

`default_nettype wire

// ===== tb/base64_decoder_checked_core_test.sv =====
// testbench for the base64 decoder: directed and random strings against a built-in decoder model
`default_nettype none

module base64_decoder_checked_core_test;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  b64d_pkg::in_word_t  in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  b64d_pkg::out_word_t out_word_o;

  base64_decoder_checked_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // decoder model state
  logic [b64d_pkg::SymW-1:0] quad_syms [b64d_pkg::GrpN];
  int unsigned               quad_pos;
  b64d_pkg::status_e         err_st;
  b64d_pkg::out_word_t       decoded_q [$];

  int unsigned n_fail;
  int unsigned n_sent;
  int unsigned cycle_cnt;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_len;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver side: long hold-off first, else random stalls
  always @(negedge clk_i) begin
    if (hold_len != 0) begin
      out_stall_i = 1'b1;
      hold_len--;
    end else begin
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
    n_fail++;
  endtask

  always @(posedge clk_i) begin : check_results
    b64d_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("word with nothing pending", out_word_o, 0);
      end else begin
        want = decoded_q.pop_front();
        if (out_word_o.is_status !== want.is_status)
          report_mismatch("is_status", out_word_o.is_status, want.is_status);
        if (out_word_o.data_byte !== want.data_byte)
          report_mismatch("data_byte", out_word_o.data_byte, want.data_byte);
        if (out_word_o.status !== want.status)
          report_mismatch("status", out_word_o.status, want.status);
        if (out_word_o.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", out_word_o.last_of_run, want.last_of_run);
      end
    end
  end

  function automatic logic [7:0] char_of(input logic [5:0] s);
    if (s < 26) return "A" + 8'(s);
    if (s < 52) return "a" + 8'(s - 26);
    if (s < 62) return "0" + 8'(s - 52);
    if (s == 62) return "+";
    return "/";
  endfunction

  function automatic logic [b64d_pkg::SymW-1:0] sextet_of(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (char_of(6'(i)) == c) return b64d_pkg::SymW'(i);
    end
    if (c == "=") return b64d_pkg::SYM_PAD;
    return b64d_pkg::SYM_BAD;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] blank_char();
    int unsigned k;
    k = $urandom_range(5);
    return (k == 5) ? 8'h20 : 8'(8'h09 + k);
  endfunction

  function automatic void push_word(input logic is_st, input logic [7:0] data,
                                    input b64d_pkg::status_e st, input logic last);
    b64d_pkg::out_word_t r;
    r.is_status   = is_st;
    r.data_byte   = data;
    r.status      = st;
    r.last_of_run = last;
    decoded_q     = {decoded_q, r};
  endfunction

  function automatic void decode_word(input b64d_pkg::in_word_t w);
    logic [b64d_pkg::SymW-1:0] sym;
    logic [7:0]                b0;
    logic [7:0]                b1;
    logic [7:0]                b2;
    b64d_pkg::status_e         st;
    if (w.kind == b64d_pkg::KIND_END) begin
      st = err_st;
      if (st == b64d_pkg::ST_OK && quad_pos != 0) st = b64d_pkg::ST_TRUNC;
      push_word(1'b1, 8'h00, st, 1'b1);
      quad_pos = 0;
      err_st   = b64d_pkg::ST_OK;
      return;
    end
    if (err_st != b64d_pkg::ST_OK || is_space(w.char_code)) return;
    sym = sextet_of(w.char_code);
    if (sym == b64d_pkg::SYM_BAD) begin
      err_st = b64d_pkg::ST_BAD_CHAR;
      return;
    end
    if (quad_pos < 3) begin
      quad_syms[quad_pos] = sym;
      quad_pos++;
      return;
    end
    quad_pos = 0;
    if (quad_syms[2] == b64d_pkg::SYM_PAD && sym != b64d_pkg::SYM_PAD) begin
      err_st = b64d_pkg::ST_BAD_PAD;
      return;
    end
    if (quad_syms[0] == b64d_pkg::SYM_PAD || quad_syms[1] == b64d_pkg::SYM_PAD) begin
      err_st = b64d_pkg::ST_EARLY_PAD;
      return;
    end
    b0 = {quad_syms[0][5:0], quad_syms[1][5:4]};
    b1 = {quad_syms[1][3:0], quad_syms[2][5:2]};
    b2 = {quad_syms[2][1:0], sym[5:0]};
    if (quad_syms[2] == b64d_pkg::SYM_PAD) begin
      push_word(1'b0, b0, b64d_pkg::ST_OK, 1'b1);
    end else if (sym == b64d_pkg::SYM_PAD) begin
      push_word(1'b0, b0, b64d_pkg::ST_OK, 1'b0);
      push_word(1'b0, b1, b64d_pkg::ST_OK, 1'b1);
    end else begin
      push_word(1'b0, b0, b64d_pkg::ST_OK, 1'b0);
      push_word(1'b0, b1, b64d_pkg::ST_OK, 1'b0);
      push_word(1'b0, b2, b64d_pkg::ST_OK, 1'b1);
    end
  endfunction

  // entered and left at a falling edge
  task automatic send_word(input b64d_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i  = w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_word(w);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_char(input logic [7:0] c);
    b64d_pkg::in_word_t w;
    w.kind      = b64d_pkg::KIND_CHAR;
    w.char_code = c;
    send_word(w);
  endtask

  task automatic send_end();
    b64d_pkg::in_word_t w;
    w.kind      = b64d_pkg::KIND_END;
    w.char_code = 8'($urandom_range(255));
    send_word(w);
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_char(t[i]);
  endtask

  task automatic send_encoded(input int n_bytes, input int unsigned blank_pct);
    logic [7:0] raw [$];
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [5:0] sx [4];
    int         left;
    for (int i = 0; i < n_bytes; i++) raw = {raw, 8'($urandom_range(255))};
    while (raw.size() != 0) begin
      left = raw.size();
      b0 = raw.pop_front();
      b1 = 8'h00;
      b2 = 8'h00;
      if (left > 1) b1 = raw.pop_front();
      if (left > 2) b2 = raw.pop_front();
      sx[0] = b0[7:2];
      sx[1] = {b0[1:0], b1[7:4]};
      sx[2] = {b1[3:0], b2[7:6]};
      sx[3] = b2[5:0];
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(99) < blank_pct) send_char(blank_char());
        if (k > left) send_char("=");
        else send_char(char_of(sx[k]));
      end
    end
    send_end();
  endtask

  task automatic send_noise(input int len);
    int unsigned r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (r < 50) send_char(char_of(6'($urandom_range(63))));
      else if (r < 65) send_char("=");
      else if (r < 80) send_char(blank_char());
      else send_char(8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 80) send_end();
  endtask

  task automatic wait_drain();
    in_valid_i = 1'b0;
    while (decoded_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic test_quads_and_pads();
    idle_pct  = 0;
    stall_pct = 0;
    send_text("////");
    send_text("AA==");
    send_text("zZ9=");
    send_end();
  endtask

  task automatic test_quad_errors();
    send_text("AB=C");
    send_char(8'hFF);
    send_end();
    send_text("=AAA");
    send_end();
    send_char(8'hFF);
    send_end();
  endtask

  task automatic test_whitespace_truncated();
    send_char(8'h20);
    send_text("Q");
    for (int c = 8'h09; c <= 8'h0D; c++) send_char(8'(c));
    send_end();
    wait_drain();
  endtask

  task automatic test_receiver_hold_off();
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk_i);
    hold_len = 48;
    @(negedge clk_i);
    send_encoded(15, 0);
    wait_drain();
  endtask

  task automatic test_sender_pause();
    idle_pct  = 20;
    stall_pct = 20;
    send_encoded(7, 10);
    send_text("QU");
    wait_drain();
    send_text("JD");
    send_end();
    wait_drain();
  endtask

  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned n_items);
    int unsigned first;
    idle_pct  = snd_pct;
    stall_pct = rcv_pct;
    first     = n_sent;
    while (n_sent - first < n_items) begin
      if ($urandom_range(99) < 75) send_encoded($urandom_range(9), 10);
      else send_noise($urandom_range(1, 10));
    end
    wait_drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_stall_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_len    = 0;
    n_fail      = 0;
    n_sent      = 0;
    cycle_cnt   = 0;
    quad_pos    = 0;
    err_st      = b64d_pkg::ST_OK;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_quads_and_pads();
    test_quad_errors();
    test_whitespace_truncated();
    test_receiver_hold_off();
    test_sender_pause();
    test_random_traffic(0, 0, 60);
    test_random_traffic(65, 0, 60);
    test_random_traffic(0, 65, 60);
    test_random_traffic(34, 34, 60);

    wait_drain();
    repeat (6) @(negedge clk_i);
    if (decoded_q.size() != 0) report_mismatch("words never delivered", 0, decoded_q.size());
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
